// File: src/rpnc_pkg.sv
// ---------------------------------------------------------------------------
// rpnc_pkg
// Shared widths, command codes and status codes of the RPN stack calculator.
// ---------------------------------------------------------------------------
`default_nettype none

package rpnc_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DEPTH_W_DEF     = $clog2(STACK_DEPTH_DEF + 1);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   data_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_DROP = 3'd1;
  localparam cmd_t CMD_ADD  = 3'd2;
  localparam cmd_t CMD_SUB  = 3'd3;
  localparam cmd_t CMD_MUL  = 3'd4;
  localparam cmd_t CMD_DIV  = 3'd5;
  localparam cmd_t CMD_MIN  = 3'd6;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UNDER   = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_DIVZERO = 2'd3;

endpackage

`default_nettype wire

// File: src/rpnc_if.sv
// ---------------------------------------------------------------------------
// rpnc_if
// Valid/ready channels of the RPN stack calculator: command in, result out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rpnc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rpnc_pkg::CMD_W-1:0]          cmd;
  logic signed [rpnc_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface rpnc_out_if #(
  parameter int unsigned DEPTH_W = rpnc_pkg::DEPTH_W_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [rpnc_pkg::DATA_W-1:0]  top_value;
  logic [DEPTH_W-1:0]                  stack_depth;
  logic [rpnc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output top_value, output stack_depth, output status,
                  input ready);
  modport sink   (input valid, input top_value, input stack_depth, input status,
                  output ready);
endinterface

`default_nettype wire

// File: src/rpnc_ram.sv
// ---------------------------------------------------------------------------
// rpnc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rpnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/rpn_stack_calculator.sv
// ---------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish integer calculator on a RAM-backed stack with one shared
// 33-bit adder/subtractor and a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one command word (cmd, push_value); out_ch returns one
//   result word per command (top_value, stack_depth, status).
//   in_ch.ready is high only while the sequencer is idle; one command is
//   worked on at a time.
//   After accept: push, drop without a new top, unused codes and errors
//   go straight to the output register; drop with a new top reads it
//   first; add and subtract read the first operand and write back;
//   multiply reads, multiplies, writes; divide reads, runs 32 restoring
//   steps on the shared subtractor, writes; minimum makes one stack read
//   and compare per entry below the top, then writes. A new command is
//   taken only once the previous result has gone into the output register.
//   The result sits in an output register: while the receiver stalls,
//   the next command is still taken and worked on; its result waits in
//   the sequencer until the output register frees up.
//   Reset empties the stack (depth zero); the RAM contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rpnc_in_if.sink   in_ch,
  rpnc_out_if.source out_ch
);

  import rpnc_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_TOP  = 3'd1;
  localparam logic [2:0] S_RD_A    = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_DIV_FIX = 3'd5;
  localparam logic [2:0] S_MIN     = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          out_valid_r, out_valid_nxt;
  // payload
  cmd_t          cmd_r, cmd_nxt;
  status_t       status_r, status_nxt;
  data_t         top_r, top_nxt;
  data_t         opa_r, opa_nxt;     // remainder / running minimum
  data_t         opb_r, opb_nxt;     // divisor magnitude
  data_t         quo_r, quo_nxt;     // dividend shifting into quotient
  data_t         prod_r, prod_nxt;
  logic          neg_r, neg_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  data_t         out_top_r, out_top_nxt;
  logic [DW-1:0] out_depth_r, out_depth_nxt;
  status_t       out_status_r, out_status_nxt;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  data_t         wdata, rdata;

  // shared adder/subtractor
  logic [DATA_W:0] alu_x, alu_y, alu_res;
  logic            alu_sub;

  logic [DW-1:0] dm1, dm2;
  logic          full;
  data_t         a_abs, b_abs;

  rpnc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

  assign dm1   = depth_r - DW'(1);
  assign dm2   = depth_r - DW'(2);
  assign full  = (depth_r == DW'(STACK_DEPTH));
  assign a_abs = rdata[DATA_W-1] ? (data_t'(0) - rdata) : rdata;
  assign b_abs = top_r[DATA_W-1] ? (data_t'(0) - top_r) : top_r;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = out_top_r;
  assign out_ch.stack_depth = out_depth_r;
  assign out_ch.status      = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    top_nxt        = top_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    quo_nxt        = quo_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    dcnt_nxt       = dcnt_r;
    idx_nxt        = idx_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;

    we      = 1'b0;
    waddr   = depth_r[AW-1:0];
    wdata   = top_r;
    raddr   = dm2[AW-1:0];
    alu_x   = {rdata[DATA_W-1], rdata};
    alu_y   = {top_r[DATA_W-1], top_r};
    alu_sub = 1'b1;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.cmd;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          case (in_ch.cmd)
            CMD_PUSH: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                wdata     = in_ch.push_value;
                top_nxt   = in_ch.push_value;
                depth_nxt = depth_r + DW'(1);
              end
            end
            CMD_DROP: begin
              if (depth_r == DW'(0)) begin
                status_nxt = ST_UNDER;
              end else begin
                depth_nxt = dm1;
                if (depth_r >= DW'(2)) begin
                  state_nxt = S_RD_TOP;   // raddr already points at new top
                end
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (depth_r < DW'(2)) begin
                status_nxt = ST_UNDER;
              end else if (in_ch.cmd == CMD_DIV && top_r == data_t'(0)) begin
                status_nxt = ST_DIVZERO;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            CMD_MIN: begin
              if (depth_r == DW'(0)) begin
                status_nxt = ST_UNDER;
              end else begin
                opa_nxt = top_r;
                if (depth_r != DW'(1)) begin
                  idx_nxt   = dm2[AW-1:0];
                  state_nxt = S_MIN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD_TOP: begin
        top_nxt   = rdata;
        state_nxt = S_OUT;
      end

      // rdata holds the first operand, top_r the second
      S_RD_A: begin
        alu_sub = (cmd_r == CMD_SUB);
        case (cmd_r)
          CMD_ADD, CMD_SUB: begin
            we        = 1'b1;
            waddr     = dm2[AW-1:0];
            wdata     = alu_res[DATA_W-1:0];
            top_nxt   = alu_res[DATA_W-1:0];
            depth_nxt = dm1;
            state_nxt = S_OUT;
          end
          CMD_MUL: begin
            prod_nxt  = rdata * top_r;
            state_nxt = S_MUL;
          end
          default: begin
            neg_nxt   = rdata[DATA_W-1] ^ top_r[DATA_W-1];
            opa_nxt   = '0;
            quo_nxt   = a_abs;
            opb_nxt   = b_abs;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        endcase
      end

      S_MUL: begin
        we        = 1'b1;
        waddr     = dm2[AW-1:0];
        wdata     = prod_r;
        top_nxt   = prod_r;
        depth_nxt = dm1;
        state_nxt = S_OUT;
      end

      // one restoring step: shift in next dividend bit, trial subtract
      S_DIV: begin
        alu_x   = {opa_r, quo_r[DATA_W-1]};
        alu_y   = {1'b0, opb_r};
        if (!alu_res[DATA_W]) begin
          opa_nxt = alu_res[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          opa_nxt = {opa_r[DATA_W-2:0], quo_r[DATA_W-1]};
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = S_DIV_FIX;
        end
      end

      S_DIV_FIX: begin
        we        = 1'b1;
        waddr     = dm2[AW-1:0];
        wdata     = neg_r ? (data_t'(0) - quo_r) : quo_r;
        top_nxt   = wdata;
        depth_nxt = dm1;
        state_nxt = S_OUT;
      end

      // rdata is entries[idx_r]; next read address goes out this cycle
      S_MIN: begin
        alu_y = {opa_r[DATA_W-1], opa_r};
        if (alu_res[DATA_W]) begin
          opa_nxt = rdata;
        end
        raddr = idx_r - AW'(1);
        if (idx_r == AW'(0)) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = alu_res[DATA_W] ? rdata : opa_r;
          top_nxt   = wdata;
          depth_nxt = DW'(1);
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = (depth_r != DW'(0)) ? top_r : data_t'(0);
          out_depth_nxt  = depth_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    top_r        <= top_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    quo_r        <= quo_nxt;
    prod_r       <= prod_nxt;
    neg_r        <= neg_nxt;
    dcnt_r       <= dcnt_nxt;
    idx_r        <= idx_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire
